// ----- rtl/core/pso_pkg.sv -----
package pso_pkg;

   localparam logic [2:0] OP_FILL_COPY   = 3'd0;
   localparam logic [2:0] OP_FILL_BLEND  = 3'd1;
   localparam logic [2:0] OP_PIXEL_COPY  = 3'd2;
   localparam logic [2:0] OP_PIXEL_BLEND = 3'd3;
   localparam logic [2:0] OP_GLYPH       = 3'd4;

   localparam logic REG_BYTE_ORDER  = 1'b0;
   localparam logic REG_SOLID_COLOR = 1'b1;

   localparam logic [7:0]  ALPHA_ZERO = 8'd0;
   localparam logic [7:0]  ALPHA_FULL = 8'd255;
   localparam logic [16:0] ROUND_BIAS = 17'd127;

   typedef enum logic [1:0] {
      MODE_KEEP  = 2'd0,
      MODE_COPY  = 2'd1,
      MODE_BLEND = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type        mode;
      logic [31:0]     color;
      logic [2:0][7:0] chan;
      logic [15:0]     x;
      logic            last;
   } blend_item_type;

   // floor(x / 255) for x below 65280
   function automatic logic [7:0] div255(input logic [16:0] x);
      logic [17:0] t;
      t = {1'b0, x} + 18'd1 + {9'd0, x[16:8]};
      return t[15:8];
   endfunction

   function automatic mode_type alpha_mode(input logic [7:0] alpha);
      mode_type m;
      if (alpha == ALPHA_ZERO) begin
         m = MODE_KEEP;
      end else if (alpha == ALPHA_FULL) begin
         m = MODE_COPY;
      end else begin
         m = MODE_BLEND;
      end
      return m;
   endfunction

endpackage

// ----- rtl/core/pso_scale.sv -----
module pso_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [2:0]              in_op,
   input  logic [31:0]             in_src,
   input  logic [7:0]              in_cov,
   input  logic [7:0]              in_dst0,
   input  logic [7:0]              in_dst1,
   input  logic [7:0]              in_dst2,
   input  logic [15:0]             in_x,
   input  logic                    in_last,
   input  logic                    byte_order,
   input  logic [31:0]             solid_color,
   output logic                    out_valid,
   input  logic                    out_ready,
   output pso_pkg::blend_item_type out_item
);
   import pso_pkg::*;

   logic             a_valid_ff, a_valid_in;
   logic [2:0]       a_op_ff;
   logic [31:0]      a_src_ff;
   logic [7:0]       a_cov_ff;
   logic [2:0][7:0]  a_chan_ff, a_chan_in;
   logic [15:0]      a_x_ff;
   logic             a_last_ff;
   logic [3:0][16:0] a_prod_ff, a_prod_in;
   logic             b_valid_ff, b_valid_in;
   blend_item_type   b_item_ff, b_item_in;
   logic             a_ready, b_ready;
   logic [31:0]      scaled;

   assign b_ready    = !b_valid_ff || out_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign in_ready   = a_ready;
   assign a_valid_in = in_valid ? 1'b1 : (a_valid_ff && !b_ready);
   assign b_valid_in = a_valid_ff ? 1'b1 : (b_valid_ff && !out_ready);

   // channels in R,G,B order
   assign a_chan_in[0] = byte_order ? in_dst2 : in_dst0;
   assign a_chan_in[1] = in_dst1;
   assign a_chan_in[2] = byte_order ? in_dst0 : in_dst2;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         a_prod_in[k] = {9'd0, in_cov} * {9'd0, solid_color[8*k +: 8]} + ROUND_BIAS;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         scaled[8*k +: 8] = div255(a_prod_ff[k]);
      end
   end

   always_comb begin
      b_item_in.chan  = a_chan_ff;
      b_item_in.x     = a_x_ff;
      b_item_in.last  = a_last_ff;
      b_item_in.color = solid_color;
      b_item_in.mode  = MODE_KEEP;
      unique case (a_op_ff)
         OP_FILL_COPY: begin
            b_item_in.mode = MODE_COPY;
         end
         OP_FILL_BLEND: begin
            b_item_in.mode = alpha_mode(solid_color[31:24]);
         end
         OP_PIXEL_COPY: begin
            b_item_in.color = a_src_ff;
            b_item_in.mode  = MODE_COPY;
         end
         OP_PIXEL_BLEND: begin
            b_item_in.color = a_src_ff;
            b_item_in.mode  = alpha_mode(a_src_ff[31:24]);
         end
         OP_GLYPH: begin
            if (a_cov_ff == ALPHA_ZERO) begin
               b_item_in.mode = MODE_KEEP;
            end else if (a_cov_ff == ALPHA_FULL) begin
               b_item_in.mode = alpha_mode(solid_color[31:24]);
            end else begin
               b_item_in.color = scaled;
               b_item_in.mode  = alpha_mode(scaled[31:24]);
            end
         end
         default: begin
            b_item_in.mode = MODE_KEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= a_valid_in;
         end
         b_valid_ff <= b_ready ? b_valid_in : b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_op_ff   <= in_op;
         a_src_ff  <= in_src;
         a_cov_ff  <= in_cov;
         a_chan_ff <= a_chan_in;
         a_x_ff    <= in_x;
         a_last_ff <= in_last;
         a_prod_ff <= a_prod_in;
      end
      if (b_ready && a_valid_ff) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

// ----- rtl/core/pso_blend.sv -----
module pso_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  pso_pkg::blend_item_type in_item,
   input  logic                    byte_order,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [7:0]              out_byte0,
   output logic [7:0]              out_byte1,
   output logic [7:0]              out_byte2,
   output logic                    out_changed,
   output logic [15:0]             out_x,
   output logic                    out_last
);
   import pso_pkg::*;

   logic             c_valid_ff, c_valid_in;
   mode_type         c_mode_ff;
   logic [31:0]      c_color_ff;
   logic [2:0][7:0]  c_chan_ff;
   logic [15:0]      c_x_ff;
   logic             c_last_ff;
   logic [2:0][16:0] c_prod_ff, c_prod_in;
   logic             d_valid_ff, d_valid_in;
   logic [2:0][7:0]  d_byte_ff, d_byte_in;
   logic             d_changed_ff;
   logic [15:0]      d_x_ff;
   logic             d_last_ff;
   logic             c_ready, d_ready;
   logic [7:0]       inv_alpha;
   logic [2:0][7:0]  result;

   assign d_ready    = !d_valid_ff || out_ready;
   assign c_ready    = !c_valid_ff || d_ready;
   assign in_ready   = c_ready;
   assign c_valid_in = in_valid ? 1'b1 : (c_valid_ff && !d_ready);
   assign d_valid_in = c_valid_ff ? 1'b1 : (d_valid_ff && !out_ready);
   assign inv_alpha  = ALPHA_FULL - in_item.color[31:24];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c_prod_in[k] = {9'd0, in_item.chan[k]} * {9'd0, inv_alpha} + ROUND_BIAS;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         case (c_mode_ff)
            MODE_COPY:  result[k] = c_color_ff[8*(2-k) +: 8];
            MODE_BLEND: result[k] = c_color_ff[8*(2-k) +: 8] + div255(c_prod_ff[k]);
            default:    result[k] = c_chan_ff[k];
         endcase
      end
   end

   // back to memory byte order
   assign d_byte_in[0] = byte_order ? result[2] : result[0];
   assign d_byte_in[1] = result[1];
   assign d_byte_in[2] = byte_order ? result[0] : result[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (c_ready) begin
            c_valid_ff <= c_valid_in;
         end
         if (d_ready) begin
            d_valid_ff <= d_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && in_valid) begin
         c_mode_ff  <= in_item.mode;
         c_color_ff <= in_item.color;
         c_chan_ff  <= in_item.chan;
         c_x_ff     <= in_item.x;
         c_last_ff  <= in_item.last;
         c_prod_ff  <= c_prod_in;
      end
      if (d_ready && c_valid_ff) begin
         d_byte_ff    <= d_byte_in;
         d_changed_ff <= (c_mode_ff != MODE_KEEP);
         d_x_ff       <= c_x_ff;
         d_last_ff    <= c_last_ff;
      end
   end

   assign out_valid   = d_valid_ff;
   assign out_byte0   = d_byte_ff[0];
   assign out_byte1   = d_byte_ff[1];
   assign out_byte2   = d_byte_ff[2];
   assign out_changed = d_changed_ff;
   assign out_x       = d_x_ff;
   assign out_last    = d_last_ff;

endmodule

// ----- rtl/core/premul_source_over_rgb24_unit.sv -----
// Per-pixel source-over compositor for an opaque 24-bit destination.
// req channel: one item per pixel carries the operation in req_tuser, the
// source pixel, glyph coverage, the three destination bytes as read and the
// pixel position in req_tdata, and the span end marker in req_tlast.
// rsp channel: one item per request, in order, with the three new
// destination bytes and the position in rsp_tdata, the written flag in
// rsp_tuser and the span end marker in rsp_tlast.
// csr port: csr_we writes csr_wdata to register csr_index (0 byte order,
// 1 solid color); write only while no pixel is in flight.
// Four register stages: glyph scale multiply, divide by 255 and color
// select, blend multiply, divide by 255 and add. Throughput is one pixel
// per clock while rsp_tready does not stall the output.
// Every stage has its own valid and load enable, so a stall on rsp_tready
// fills bubbles first and then holds the four stages in place; req_tready
// drops only when all four are full.
// Reset clears all valid bits and both registers (RGB order, color 0).
module premul_source_over_rgb24_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // src_pixel, coverage, dst_byte0..2, pixel_x
   input  logic [2:0]  req_tuser,   // req_type
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_byte0..2, out_x
   output logic        rsp_tuser,   // changed
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import pso_pkg::*;

   logic           byte_order_ff;
   logic [31:0]    solid_color_ff;
   logic           mid_valid, mid_ready;
   blend_item_type mid_item;
   logic [7:0]     byte0, byte1, byte2;
   logic [15:0]    out_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_order_ff  <= 1'b0;
         solid_color_ff <= 32'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_BYTE_ORDER:  byte_order_ff  <= csr_wdata[0];
            REG_SOLID_COLOR: solid_color_ff <= csr_wdata;
            default:         byte_order_ff  <= byte_order_ff;
         endcase
      end
   end

   pso_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_op       (req_tuser),
      .in_src      (req_tdata[31:0]),
      .in_cov      (req_tdata[39:32]),
      .in_dst0     (req_tdata[47:40]),
      .in_dst1     (req_tdata[55:48]),
      .in_dst2     (req_tdata[63:56]),
      .in_x        (req_tdata[79:64]),
      .in_last     (req_tlast),
      .byte_order  (byte_order_ff),
      .solid_color (solid_color_ff),
      .out_valid   (mid_valid),
      .out_ready   (mid_ready),
      .out_item    (mid_item)
   );

   pso_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mid_valid),
      .in_ready    (mid_ready),
      .in_item     (mid_item),
      .byte_order  (byte_order_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte0   (byte0),
      .out_byte1   (byte1),
      .out_byte2   (byte2),
      .out_changed (rsp_tuser),
      .out_x       (out_x),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {out_x, byte2, byte1, byte0};

endmodule

// ----- tb/pso_pixel_checker.sv -----
`timescale 1ns / 100ps

module pso_pixel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,   // src_pixel, coverage, dst_byte0..2, pixel_x
   input  logic [2:0]  req_tuser,   // req_type
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // out_byte0..2, out_x
   input  logic        rsp_tuser,   // changed
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatches,
   output int          outstanding,
   output int          results,
   output int          written
);
   import pso_pkg::*;

   typedef struct packed {
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic        changed;
      logic [15:0] x;
      logic        last;
   } pixel_out_type;

   logic          order_bgr = 1'b0;
   logic [31:0]   fill_color = '0;
   pixel_out_type want_pixels[$];
   int            fail_count = 0;
   int            n_results = 0;
   int            n_written = 0;

   // round(a * b / 255)
   function automatic logic [7:0] mul_div255(input logic [7:0] a, input logic [7:0] b);
      int unsigned p;
      p = int'(a) * int'(b) + 127;
      return 8'(p / 255);
   endfunction

   // source-over of a premultiplied argb color onto {r, g, b}
   function automatic logic over_rgb(input logic [31:0] color, inout logic [23:0] rgb);
      logic [7:0] alpha;
      logic [7:0] s;
      int         k;
      alpha = color[31:24];
      if (alpha == ALPHA_ZERO) begin
         return 1'b0;
      end
      for (k = 0; k < 3; k++) begin
         s = color[8*k +: 8];
         if (alpha == ALPHA_FULL) begin
            rgb[8*k +: 8] = s;
         end else begin
            rgb[8*k +: 8] = 8'(s + mul_div255(rgb[8*k +: 8], ALPHA_FULL - alpha));
         end
      end
      return 1'b1;
   endfunction

   function automatic pixel_out_type composite_pixel(
      input logic [2:0]  op,
      input logic [31:0] src,
      input logic [7:0]  cov,
      input logic [7:0]  b0,
      input logic [7:0]  b1,
      input logic [7:0]  b2,
      input logic [15:0] x,
      input logic        last,
      input logic        bgr,
      input logic [31:0] color
   );
      logic [23:0]   rgb;
      logic [31:0]   glyph_color;
      logic          wr;
      pixel_out_type r;
      int            k;
      rgb = bgr ? {b2, b1, b0} : {b0, b1, b2};
      wr = 1'b0;
      case (op)
         OP_FILL_COPY: begin
            rgb = color[23:0];
            wr = 1'b1;
         end
         OP_FILL_BLEND: begin
            wr = over_rgb(color, rgb);
         end
         OP_PIXEL_COPY: begin
            rgb = src[23:0];
            wr = 1'b1;
         end
         OP_PIXEL_BLEND: begin
            wr = over_rgb(src, rgb);
         end
         OP_GLYPH: begin
            if (cov != '0) begin
               glyph_color = color;
               if (cov != '1) begin
                  for (k = 0; k < 4; k++) begin
                     glyph_color[8*k +: 8] = mul_div255(color[8*k +: 8], cov);
                  end
               end
               wr = over_rgb(glyph_color, rgb);
            end
         end
         default: begin
            wr = 1'b0;
         end
      endcase
      if (wr) begin
         r.byte0 = bgr ? rgb[7:0] : rgb[23:16];
         r.byte1 = rgb[15:8];
         r.byte2 = bgr ? rgb[23:16] : rgb[7:0];
      end else begin
         r.byte0 = b0;
         r.byte1 = b1;
         r.byte2 = b2;
      end
      r.changed = wr;
      r.x = x;
      r.last = last;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_out_type want;
      pixel_out_type got;
      if (reset) begin
         order_bgr = 1'b0;
         fill_color = '0;
         want_pixels.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_BYTE_ORDER) begin
               order_bgr = csr_wdata[0];
            end else begin
               fill_color = csr_wdata;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.byte0 = rsp_tdata[7:0];
            got.byte1 = rsp_tdata[15:8];
            got.byte2 = rsp_tdata[23:16];
            got.changed = rsp_tuser;
            got.x = rsp_tdata[39:24];
            got.last = rsp_tlast;
            n_results++;
            if (got.changed) begin
               n_written++;
            end
            if (want_pixels.size() == 0) begin
               $error("result item at x %0d with nothing expected", got.x);
               fail_count++;
            end else begin
               want = want_pixels.pop_front();
               check_field("out_byte0", want.byte0, got.byte0);
               check_field("out_byte1", want.byte1, got.byte1);
               check_field("out_byte2", want.byte2, got.byte2);
               check_field("changed", want.changed, got.changed);
               check_field("out_x", want.x, got.x);
               check_field("last", want.last, got.last);
            end
         end
         if (req_tvalid && req_tready) begin
            want_pixels.push_back(composite_pixel(req_tuser, req_tdata[31:0],
               req_tdata[39:32], req_tdata[47:40], req_tdata[55:48],
               req_tdata[63:56], req_tdata[79:64], req_tlast, order_bgr, fill_color));
         end
      end
      outstanding <= want_pixels.size();
      mismatches <= fail_count;
      results <= n_results;
      written <= n_written;
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import pso_pkg::*;

   localparam int         CYCLE_LIMIT = 400000;
   localparam int         DRAIN_CYCLES = 10;
   localparam int         PHASE_ITEMS = 325;
   localparam logic [2:0] OP_UNDEF_LO = 3'd5;
   localparam logic [2:0] OP_UNDEF_HI = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // src_pixel, coverage, dst_byte0..2, pixel_x
   logic [2:0]  req_tuser = '0;   // req_type
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // out_byte0..2, out_x
   logic        rsp_tuser;        // changed
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;

   logic quiet = 1'b0;
   int   cycles = 0;
   int   pixels_sent = 0;
   int   settings_used = 0;
   int   mismatches;
   int   outstanding;
   int   results;
   int   written;

   premul_source_over_rgb24_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pso_pixel_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .results     (results),
      .written     (written)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side backpressure
   initial begin : rsp_side
      int n;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 17);
         end else begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 24);
         end
         repeat (n - 1) @(posedge clock);
      end
   end

   task automatic send_pixel(input logic [2:0] op, input logic [31:0] src,
                             input logic [7:0] cov, input logic [7:0] b0,
                             input logic [7:0] b1, input logic [7:0] b2,
                             input logic [15:0] x, input logic last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {x, b2, b1, b0, cov, src};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   task automatic set_reg(input logic idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic rand_pixel();
      logic [2:0]  op;
      logic [31:0] src;
      logic [7:0]  cov;
      if ($urandom_range(0, 19) == 0) begin
         op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      end else begin
         op = 3'($urandom_range(OP_FILL_COPY, OP_GLYPH));
      end
      src = $urandom;
      case ($urandom_range(0, 3))
         0: src[31:24] = ALPHA_ZERO;
         1: src[31:24] = ALPHA_FULL;
         default: ;
      endcase
      cov = 8'($urandom);
      case ($urandom_range(0, 3))
         0: cov = '0;
         1: cov = '1;
         default: ;
      endcase
      send_pixel(op, src, cov, 8'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), $urandom_range(0, 7) == 0);
   endtask

   initial begin : stimulus
      logic        order_list[6];
      logic [31:0] color_list[6];
      logic [31:0] color;
      int          p;
      order_list = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      color_list = '{32'h0000_0000, 32'hffff_ffff, 32'h80ff_4020, 32'h00a0_b0c0,
                     32'h0, 32'h0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_reg(REG_SOLID_COLOR, 32'hc080_4020);
      settings_used++;
      send_pixel(OP_FILL_COPY, 32'h0, 8'h00, 8'h12, 8'h34, 8'h56, 16'd0, 1'b0);
      send_pixel(OP_FILL_BLEND, 32'h0, 8'h00, 8'hff, 8'hff, 8'hff, 16'd1, 1'b0);
      send_pixel(OP_PIXEL_COPY, 32'h40a0_b0c0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd2, 1'b0);
      // transparent, opaque, partial and wrapping source
      send_pixel(OP_PIXEL_BLEND, 32'h00ff_ffff, 8'h00, 8'h11, 8'h22, 8'h33, 16'd3, 1'b0);
      send_pixel(OP_PIXEL_BLEND, 32'hff10_2030, 8'h00, 8'h11, 8'h22, 8'h33, 16'd4, 1'b0);
      send_pixel(OP_PIXEL_BLEND, 32'h8040_2010, 8'h00, 8'hff, 8'hff, 8'hff, 16'd5, 1'b0);
      send_pixel(OP_PIXEL_BLEND, 32'h10ff_ffff, 8'h00, 8'hff, 8'hff, 8'hff, 16'd6, 1'b0);
      send_pixel(OP_PIXEL_BLEND, 32'h01ff_ffff, 8'h00, 8'hff, 8'hff, 8'hff, 16'd7, 1'b0);
      // glyph coverage none, full, half, minimal
      send_pixel(OP_GLYPH, 32'h0, 8'h00, 8'h55, 8'h66, 8'h77, 16'd8, 1'b0);
      send_pixel(OP_GLYPH, 32'h0, 8'hff, 8'h55, 8'h66, 8'h77, 16'd9, 1'b0);
      send_pixel(OP_GLYPH, 32'h0, 8'h80, 8'h55, 8'h66, 8'h77, 16'd10, 1'b0);
      send_pixel(OP_GLYPH, 32'h0, 8'h01, 8'h55, 8'h66, 8'h77, 16'd11, 1'b1);
      send_pixel(OP_UNDEF_LO, 32'hffff_ffff, 8'hff, 8'h9a, 8'hbc, 8'hde, 16'd12, 1'b0);
      send_pixel(OP_UNDEF_HI, 32'hffff_ffff, 8'hff, 8'h9a, 8'hbc, 8'hde, 16'd13, 1'b1);
      send_pixel(OP_PIXEL_BLEND, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 1'b1);
      send_pixel(OP_FILL_COPY, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0);
      wait_idle();

      set_reg(REG_BYTE_ORDER, 32'd1);
      settings_used++;
      send_pixel(OP_FILL_COPY, 32'h0, 8'h00, 8'h12, 8'h34, 8'h56, 16'd20, 1'b0);
      send_pixel(OP_FILL_BLEND, 32'h0, 8'h00, 8'h12, 8'h34, 8'h56, 16'd21, 1'b0);
      send_pixel(OP_PIXEL_BLEND, 32'h8040_2010, 8'h00, 8'h10, 8'h80, 8'hf0, 16'd22, 1'b0);
      send_pixel(OP_GLYPH, 32'h0, 8'h60, 8'h10, 8'h80, 8'hf0, 16'd23, 1'b1);

      for (p = 0; p < 6; p++) begin
         color = (p >= 4) ? $urandom : color_list[p];
         if (p == 5) begin
            quiet = 1'b1;
         end
         wait_idle();
         set_reg(REG_BYTE_ORDER, {31'd0, order_list[p]});
         set_reg(REG_SOLID_COLOR, color);
         settings_used++;
         repeat (PHASE_ITEMS) rand_pixel();
      end
      wait_idle();

      $display("%0d pixels in %0d register settings, %0d results checked", pixels_sent,
               settings_used, results);
      $display("%0d pixels written, %0d kept", written, results - written);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/pso_pkg.sv
rtl/core/pso_scale.sv
rtl/core/pso_blend.sv
rtl/core/premul_source_over_rgb24_unit.sv
tb/pso_pixel_checker.sv
tb/tb.sv
